@@ rtl/motion_zone_bbox_hold_unit_assert.svh @@
// Assertion macros for the motion zone bounding-box hold unit.
// Included by the top-level RTL file, which checks its own sequencing.
`ifndef MOTION_ZONE_BBOX_HOLD_UNIT_ASSERT_SVH
`define MOTION_ZONE_BBOX_HOLD_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define MZBH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("motion zone unit: implication check failed");
// Next-cycle implication.
`define MZBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("motion zone unit: next-cycle check failed");
`else
`define MZBH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MZBH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/mzbh_pkg.sv @@
// Shared types for the motion zone bounding-box hold unit.
// No dependencies; used by the divider and the top level.
package mzbh_pkg;

   // Configuration register indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_GRID_COLS    = 3'd0,
      REG_GRID_ROWS    = 3'd1,
      REG_ZONE_COUNT   = 3'd2,
      REG_FRAME_WIDTH  = 3'd3,
      REG_FRAME_HEIGHT = 3'd4,
      REG_HOLD_TIME    = 3'd5
   } reg_index_type;

   localparam int DIV_WIDTH  = 13;
   localparam int DSOR_WIDTH = 5;

   // Request to the shared cell-size divider.
   typedef struct packed {
      logic                  start;
      logic [DIV_WIDTH-1:0]  dividend;
      logic [DSOR_WIDTH-1:0] divisor;
   } div_req_type;

endpackage

@@ rtl/mzbh_div.sv @@
// Restoring divider, one quotient bit per cycle, for the cell size.
// Depends on mzbh_pkg for the request struct and widths.
module mzbh_div
   import mzbh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          req,
   output logic                 busy,
   output logic [DIV_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = $clog2(DIV_WIDTH + 1);

   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DSOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]  quo_ff, quo_in;
   logic [DSOR_WIDTH-1:0] dsor_ff, dsor_in;
   logic [DSOR_WIDTH:0]   shifted;
   logic                  fits;

   // One shift-and-subtract step per cycle.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
      fits    = shifted >= {1'b0, dsor_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      if (req.start) begin
         cnt_in  = CNT_WIDTH'(DIV_WIDTH);
         rem_in  = '0;
         quo_in  = req.dividend;
         dsor_in = req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? DSOR_WIDTH'(shifted - {1'b0, dsor_ff}) : shifted[DSOR_WIDTH-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

@@ rtl/motion_zone_bbox_hold_unit.sv @@
// Motion zone bounding-box hold unit: top level with sequencer and registers.
// Depends on mzbh_pkg, mzbh_div and motion_zone_bbox_hold_unit_assert.svh.
//
// Usage: each req beat carries one frame's zone motion mask and its time
// in microseconds; each accepted beat yields exactly one rsp beat with the
// motion flag, held detection count, held pixel box and last motion time.
// The user must write registers over the csr port only while no frame is
// in flight; the block itself does not enforce this. One frame is handled
// at a time and req_tready is low meanwhile. Zones are scanned one per
// cycle; the box then needs two cell size divisions on the shared divider
// and four products on one shared multiplier. The rsp beat sits in an
// output register: if the receiver stalls, the next frame is still
// accepted and worked on, and waits only to load the output register.
// Reset clears the motion state and box to zero and loads the register
// defaults; no rsp beat is pending after reset.
module motion_zone_bbox_hold_unit
   import mzbh_pkg::*;
#(
   parameter int ZONES = 16
)
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata: zone_mask[15:0], now_us[78:16], zero pad[79]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   // rsp_tdata: motion[0], box_count[1], box_left[13:2], box_top[25:14],
   // box_right[38:26], box_bottom[51:39], last_motion_us[114:52], pad[119:115]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

`include "motion_zone_bbox_hold_unit_assert.svh"

   localparam int SCAN_LIM = (ZONES < 16) ? ZONES : 16;
   localparam logic [4:0]  SCAN_LIM_W = 5'(SCAN_LIM);
   localparam logic [15:0] LIM_MASK   = 16'((17'd1 << SCAN_LIM) - 17'd1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FLAG, ST_SCAN, ST_DIVW_GO, ST_DIVW_RUN, ST_DIVH_GO, ST_DIVH_RUN,
      ST_MUL, ST_CLAMP, ST_HOLD_SUB, ST_HOLD_CMP, ST_WRITE
   } state_type;

   // Configuration registers.
   logic [4:0]  cols_ff, rows_ff, zcnt_ff;
   logic [12:0] fw_ff, fh_ff;
   logic [31:0] hold_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= '0;
         rows_ff <= '0;
         zcnt_ff <= '0;
         fw_ff   <= 13'd640;
         fh_ff   <= 13'd360;
         hold_ff <= 32'd2000000;
      end else if (csr_wr) begin
         case (reg_index_type'(csr_idx))
            REG_GRID_COLS:    cols_ff <= csr_pwdata[4:0];
            REG_GRID_ROWS:    rows_ff <= csr_pwdata[4:0];
            REG_ZONE_COUNT:   zcnt_ff <= csr_pwdata[4:0];
            REG_FRAME_WIDTH:  fw_ff   <= csr_pwdata[12:0];
            REG_FRAME_HEIGHT: fh_ff   <= csr_pwdata[12:0];
            REG_HOLD_TIME:    hold_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_index_type'(csr_idx))
         REG_GRID_COLS:    csr_prdata = {27'd0, cols_ff};
         REG_GRID_ROWS:    csr_prdata = {27'd0, rows_ff};
         REG_ZONE_COUNT:   csr_prdata = {27'd0, zcnt_ff};
         REG_FRAME_WIDTH:  csr_prdata = {19'd0, fw_ff};
         REG_FRAME_HEIGHT: csr_prdata = {19'd0, fh_ff};
         REG_HOLD_TIME:    csr_prdata = hold_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // Sequencer, frame and motion state.
   state_type          state_ff, state_in;
   logic [15:0]        mask_ff, mask_in;
   logic [62:0]        now_ff, now_in;
   logic [4:0]         n_ff, n_in;
   logic [3:0]         idx_ff, idx_in;
   logic [3:0]         col_ff, col_in, row_ff, row_in;
   logic               found_ff, found_in;
   logic [3:0]         minc_ff, minc_in, maxc_ff, maxc_in;
   logic [3:0]         minr_ff, minr_in, maxr_ff, maxr_in;
   logic [12:0]        cw_ff, cw_in, ch_ff, ch_in;
   logic [1:0]         k_ff, k_in;
   logic [17:0]        prod_ff, prod_in;
   logic [63:0]        diff_ff, diff_in;
   logic               flag_ff, flag_in;
   logic [62:0]        stamp_ff, stamp_in;
   logic               count_ff, count_in;
   logic signed [12:0] box_ff [4];
   logic signed [12:0] box_in [4];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [119:0]       rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   logic        div_busy;
   logic [12:0] div_quo;

   mzbh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   logic [4:0]         mul_a;
   logic [12:0]        mul_b;
   logic signed [12:0] clamped;
   logic               grid_mode;
   logic [4:0]         n_sel;

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      now_in       = now_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      found_in     = found_ff;
      minc_in      = minc_ff;
      maxc_in      = maxc_ff;
      minr_in      = minr_ff;
      maxr_in      = maxr_ff;
      cw_in        = cw_ff;
      ch_in        = ch_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      diff_in      = diff_ff;
      flag_in      = flag_ff;
      stamp_in     = stamp_ff;
      count_in     = count_ff;
      box_in       = box_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      grid_mode    = (cols_ff != '0) && (rows_ff != '0) && (zcnt_ff != '0);
      n_sel        = (zcnt_ff < SCAN_LIM_W) ? zcnt_ff : SCAN_LIM_W;

      // Shared multiplier operands: left, top, right + 1, bottom + 1.
      case (k_ff)
         2'd0:    mul_a = {1'b0, minc_ff};
         2'd1:    mul_a = {1'b0, minr_ff};
         2'd2:    mul_a = 5'({1'b0, maxc_ff} + 5'd1);
         default: mul_a = 5'({1'b0, maxr_ff} + 5'd1);
      endcase
      mul_b = k_ff[0] ? ch_ff : cw_ff;

      // Clamp of the registered product into the box field.
      if (!k_ff[1]) begin
         clamped = (prod_ff > 18'd4095) ? 13'sd4095 : $signed({1'b0, prod_ff[11:0]});
      end else if (prod_ff == '0) begin
         clamped = -13'sd1;
      end else if (prod_ff > 18'd4096) begin
         clamped = 13'sd4095;
      end else begin
         clamped = $signed(13'(prod_ff - 18'd1));
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mask_in  = req_tdata[15:0];
               now_in   = req_tdata[78:16];
               n_in     = n_sel;
               idx_in   = '0;
               col_in   = '0;
               row_in   = '0;
               found_in = 1'b0;
               state_in = grid_mode ? ST_SCAN : ST_FLAG;
            end
         end
         ST_FLAG: begin
            flag_in = |(mask_ff & LIM_MASK);
            if (|(mask_ff & LIM_MASK)) begin
               stamp_in = now_ff;
            end
            state_in = ST_WRITE;
         end
         ST_SCAN: begin
            // One zone per cycle, column and row stepped alongside.
            if (mask_ff[idx_ff]) begin
               found_in = 1'b1;
               if (!found_ff || col_ff < minc_ff) minc_in = col_ff;
               if (!found_ff || col_ff > maxc_ff) maxc_in = col_ff;
               if (!found_ff || row_ff < minr_ff) minr_in = row_ff;
               if (!found_ff || row_ff > maxr_ff) maxr_in = row_ff;
            end
            if (5'({1'b0, col_ff} + 5'd1) == cols_ff) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if ({1'b0, idx_ff} == 5'(n_ff - 5'd1)) begin
               state_in = (found_ff || mask_ff[idx_ff]) ? ST_DIVW_GO : ST_HOLD_SUB;
            end
         end
         ST_DIVW_GO: begin
            div_req  = '{start: 1'b1, dividend: fw_ff, divisor: cols_ff};
            state_in = ST_DIVW_RUN;
         end
         ST_DIVW_RUN: begin
            if (!div_busy) begin
               cw_in    = div_quo;
               state_in = ST_DIVH_GO;
            end
         end
         ST_DIVH_GO: begin
            div_req  = '{start: 1'b1, dividend: fh_ff, divisor: rows_ff};
            state_in = ST_DIVH_RUN;
         end
         ST_DIVH_RUN: begin
            if (!div_busy) begin
               ch_in    = div_quo;
               k_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 18'(mul_a) * 18'(mul_b);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            box_in[k_ff] = clamped;
            k_in         = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               flag_in  = 1'b1;
               stamp_in = now_ff;
               count_in = 1'b1;
               state_in = ST_WRITE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_HOLD_SUB: begin
            diff_in  = {1'b0, now_ff} - {1'b0, stamp_ff};
            state_in = ST_HOLD_CMP;
         end
         ST_HOLD_CMP: begin
            // A borrow means time went backwards: keep holding.
            if (flag_ff && !diff_ff[63] &&
                ((diff_ff[62:32] != '0) || (diff_ff[31:0] > hold_ff))) begin
               flag_in  = 1'b0;
               count_in = 1'b0;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, stamp_ff, box_ff[3], box_ff[2],
                               box_ff[1][11:0], box_ff[0][11:0], count_ff, flag_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
         stamp_ff     <= '0;
         count_ff     <= 1'b0;
         box_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
         stamp_ff     <= stamp_in;
         count_ff     <= count_in;
         box_ff       <= box_in;
      end
      mask_ff     <= mask_in;
      now_ff      <= now_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      found_ff    <= found_in;
      minc_ff     <= minc_in;
      maxc_ff     <= maxc_in;
      minr_ff     <= minr_in;
      maxr_ff     <= maxr_in;
      cw_ff       <= cw_in;
      ch_ff       <= ch_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A new rsp beat only comes out of the write-back state.
   `MZBH_ASSERT_IMPLY(a_rsp_from_write, clock, reset, $rose(rsp_tvalid), $past(state_ff == ST_WRITE))
   // The divider runs only while the sequencer waits on it.
   `MZBH_ASSERT_IMPLY(a_div_owned, clock, reset, div_busy, (state_ff == ST_DIVW_RUN) || (state_ff == ST_DIVH_RUN))
   // The zone scan never passes the zones in range.
   `MZBH_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_SCAN, ({1'b0, idx_ff} < n_ff))
   // An accepted frame leaves the idle state at once.
   `MZBH_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

@@ tb/mzbh_frame_checker.sv @@
// Scoreboard for the motion zone bounding-box hold unit: predicts each frame summary.
// Watches the req, rsp and csr ports of the block; depends on mzbh_pkg.
module mzbh_frame_checker
   import mzbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [79:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_frames
);

   // One frame summary as it travels on the rsp channel.
   typedef struct packed {
      logic        motion;
      logic        box_count;
      logic [11:0] box_left;
      logic [11:0] box_top;
      logic [12:0] box_right;
      logic [12:0] box_bottom;
      logic [62:0] last_us;
   } frame_summary_t;

   // Register copy.
   logic [4:0]  grid_cols, grid_rows, zone_count;
   logic [12:0] frame_w, frame_h;
   logic [31:0] hold_us;

   // Motion state copy.
   logic        motion_on;
   logic [62:0] motion_stamp;
   logic        held_count;
   logic [11:0] held_left, held_top;
   logic [12:0] held_right, held_bottom;

   frame_summary_t expected_frames[$];
   int mismatches = 0;
   int pending = 0;

   assign fail_count     = mismatches;
   assign pending_frames = pending;

   task automatic report_mismatch(string line);
      $display("%0t: mismatch: %s", $realtime, line);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic int clamp_span(int v, int lo, int hi);
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic logic [31:0] csr_value(logic [2:0] idx);
      case (idx)
         REG_GRID_COLS:    return 32'(grid_cols);
         REG_GRID_ROWS:    return 32'(grid_rows);
         REG_ZONE_COUNT:   return 32'(zone_count);
         REG_FRAME_WIDTH:  return 32'(frame_w);
         REG_FRAME_HEIGHT: return 32'(frame_h);
         REG_HOLD_TIME:    return hold_us;
         default:          return 32'd0;
      endcase
   endfunction

   // Advance the motion state by one frame and return the summary it yields.
   function automatic frame_summary_t summarize_frame(logic [15:0] mask, logic [62:0] now);
      int min_c, max_c, min_r, max_r, cell_w, cell_h, scanned, c, r;
      frame_summary_t s;
      if (grid_cols == 0 || grid_rows == 0 || zone_count == 0) begin
         // Flag mode: any zone bit, cleared at once, box left alone.
         motion_on = (mask != 16'd0);
         if (mask != 16'd0)
            motion_stamp = now;
      end else begin
         min_c = int'(grid_cols);
         max_c = -1;
         min_r = int'(grid_rows);
         max_r = -1;
         scanned = (zone_count < 16) ? int'(zone_count) : 16;
         for (int i = 0; i < scanned; i++) begin
            if (mask[i]) begin
               c = i % int'(grid_cols);
               r = i / int'(grid_cols);
               if (c < min_c) min_c = c;
               if (c > max_c) max_c = c;
               if (r < min_r) min_r = r;
               if (r > max_r) max_r = r;
            end
         end
         if (max_c >= 0) begin
            cell_w = int'(frame_w) / int'(grid_cols);
            cell_h = int'(frame_h) / int'(grid_rows);
            motion_on    = 1'b1;
            motion_stamp = now;
            held_count   = 1'b1;
            held_left    = 12'(clamp_span(min_c * cell_w, 0, 4095));
            held_top     = 12'(clamp_span(min_r * cell_h, 0, 4095));
            held_right   = 13'(clamp_span((max_c + 1) * cell_w - 1, -1, 4095));
            held_bottom  = 13'(clamp_span((max_r + 1) * cell_h - 1, -1, 4095));
         end else if (motion_on && now >= motion_stamp &&
                      (now - motion_stamp) > 63'(hold_us)) begin
            // Hold time ran out with no motion: drop the detection.
            motion_on  = 1'b0;
            held_count = 1'b0;
         end
      end
      s.motion     = motion_on;
      s.box_count  = held_count;
      s.box_left   = held_left;
      s.box_top    = held_top;
      s.box_right  = held_right;
      s.box_bottom = held_bottom;
      s.last_us    = motion_stamp;
      return s;
   endfunction

   // Sample every port at the clock edge; outputs change only after it.
   always @(posedge clock) begin
      frame_summary_t got, want;
      if (reset) begin
         grid_cols    = 5'd0;
         grid_rows    = 5'd0;
         zone_count   = 5'd0;
         frame_w      = 13'd640;
         frame_h      = 13'd360;
         hold_us      = 32'd2000000;
         motion_on    = 1'b0;
         motion_stamp = '0;
         held_count   = 1'b0;
         held_left    = '0;
         held_top     = '0;
         held_right   = '0;
         held_bottom  = '0;
         expected_frames.delete();
      end else begin
         // Register write and read back.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[4:2])
                  REG_GRID_COLS:    grid_cols  = csr_pwdata[4:0];
                  REG_GRID_ROWS:    grid_rows  = csr_pwdata[4:0];
                  REG_ZONE_COUNT:   zone_count = csr_pwdata[4:0];
                  REG_FRAME_WIDTH:  frame_w    = csr_pwdata[12:0];
                  REG_FRAME_HEIGHT: frame_h    = csr_pwdata[12:0];
                  REG_HOLD_TIME:    hold_us    = csr_pwdata;
                  default: ;
               endcase
            end else begin
               check_field($sformatf("register %0d", csr_paddr[4:2]), 64'(csr_prdata),
                           64'(csr_value(csr_paddr[4:2])));
            end
         end
         // Frame beat in.
         if (req_tvalid && req_tready)
            expected_frames.push_back(summarize_frame(req_tdata[15:0], req_tdata[78:16]));
         // Summary beat out.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("summary beat 0x%0h with no frame waiting", rsp_tdata));
            end else begin
               want = expected_frames.pop_front();
               got.motion     = rsp_tdata[0];
               got.box_count  = rsp_tdata[1];
               got.box_left   = rsp_tdata[13:2];
               got.box_top    = rsp_tdata[25:14];
               got.box_right  = rsp_tdata[38:26];
               got.box_bottom = rsp_tdata[51:39];
               got.last_us    = rsp_tdata[114:52];
               check_field("motion", 64'(got.motion), 64'(want.motion));
               check_field("box_count", 64'(got.box_count), 64'(want.box_count));
               check_field("box_left", 64'(got.box_left), 64'(want.box_left));
               check_field("box_top", 64'(got.box_top), 64'(want.box_top));
               check_field("box_right", 64'(got.box_right), 64'(want.box_right));
               check_field("box_bottom", 64'(got.box_bottom), 64'(want.box_bottom));
               check_field("last_motion_us", 64'(got.last_us), 64'(want.last_us));
            end
         end
      end
      pending = expected_frames.size();
   end

endmodule

@@ tb/tb_motion_zone_bbox_hold_unit.sv @@
// Testbench top for the motion zone bounding-box hold unit: stimulus and verdict.
// Depends on mzbh_pkg, the block and mzbh_frame_checker.
module tb_motion_zone_bbox_hold_unit;
   import mzbh_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 60;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // req_tdata: zone_mask[15:0], now_us[78:16], zero pad[79]
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // rsp_tdata: motion[0], box_count[1], box_left[13:2], box_top[25:14],
   // box_right[38:26], box_bottom[51:39], last_motion_us[114:52], pad[119:115]
   logic [119:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int fail_count;
   int pending_frames;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   // Frame time line and the last time a frame carried any motion bit.
   logic [62:0] frame_us = '0;
   logic [62:0] motion_us = '0;
   logic [31:0] hold_setting = 32'd2000000;

   motion_zone_bbox_hold_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mzbh_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending_frames (pending_frames)
   );

   always #10 clock = ~clock;

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Count cycles in which no beat of any kind is accepted.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Watchdog: the run is stuck.
   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 80; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 80; end
         default:       begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
   endtask

   // Offer one frame beat and wait until it is taken.
   task automatic drive_frame(logic [15:0] mask, logic [62:0] now);
      frame_us = now;
      if (mask != 16'd0)
         motion_us = now;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, now, mask};
      do @(posedge clock); while (!req_tready);
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(reg_index_type idx, logic write, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain every outstanding summary, then let the block go fully idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_frames == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(int cols, int rows, int zones, int width, int height,
                                logic [31:0] hold);
      settle();
      csr_access(REG_GRID_COLS, 1'b1, 32'(cols));
      csr_access(REG_GRID_ROWS, 1'b1, 32'(rows));
      csr_access(REG_ZONE_COUNT, 1'b1, 32'(zones));
      csr_access(REG_FRAME_WIDTH, 1'b1, 32'(width));
      csr_access(REG_FRAME_HEIGHT, 1'b1, 32'(height));
      csr_access(REG_HOLD_TIME, 1'b1, hold);
      for (int i = 0; i <= int'(REG_HOLD_TIME); i++)
         csr_access(reg_index_type'(i), 1'b0, 32'd0);
      hold_setting = hold;
   endtask

   // Random frame: mostly sparse or empty masks, with time steps aimed at the hold edge.
   task automatic random_frame();
      logic [15:0] mask;
      logic [62:0] now;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         mask = 16'd0;
      else if (pick < 70)
         mask = 16'd1 << $urandom_range(0, 15);
      else if (pick < 85)
         mask = 16'($urandom & $urandom);
      else
         mask = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45)
         now = frame_us + 63'($urandom_range(0, hold_setting / 4));
      else if (pick < 75)
         now = motion_us + 63'(hold_setting) + 63'($urandom_range(0, 4)) - 63'd2;
      else if (pick < 85)
         now = frame_us + 63'({$urandom, $urandom});
      else if (pick < 93)
         now = frame_us - 63'($urandom_range(1, 1000));
      else
         now = 63'({$urandom, $urandom});
      drive_frame(mask, now);
   endtask

   // Random frames spread over all four idling patterns.
   task automatic run_random(int count);
      for (int k = 0; k < 4; k++) begin
         set_idling(idle_mode_type'(k));
         repeat (count / 4) random_frame();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // Flag mode at the reset settings: set and clear at once.
      drive_frame(16'h0000, 63'd0);
      drive_frame(16'h0001, 63'd10);
      drive_frame(16'h8000, 63'd20);
      drive_frame(16'h0000, 63'd30);
      drive_frame(16'hFFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      run_random(100);

      // Four by four grid: corners, full mask, hold edge, time going backwards.
      apply_setting(4, 4, 16, 640, 360, 32'd1000);
      drive_frame(16'h0001, 63'd100);
      drive_frame(16'h8000, 63'd200);
      drive_frame(16'hFFFF, 63'd300);
      drive_frame(16'h0000, 63'd1300);
      drive_frame(16'h0000, 63'd1301);
      drive_frame(16'h0000, 63'd1302);
      drive_frame(16'h0240, 63'd5000);
      drive_frame(16'h0000, 63'd4000);
      drive_frame(16'h0000, 63'h7FFF_FFFF_FFFF_FFFF);
      drive_frame(16'h5A5A, 63'h7FFF_FFFF_FFFF_FFFF);
      drive_frame(16'h0000, 63'd0);
      drive_frame(16'hA5A5, 63'h4000_0000_0000_0000);
      run_random(140);

      // Largest grid and frame with no hold at all.
      apply_setting(16, 16, 16, 4096, 4096, 32'd0);
      run_random(140);
      // One cell grid with zones past the last row: box rows saturate.
      apply_setting(1, 1, 16, 4096, 4096, 32'hFFFF_FFFF);
      run_random(140);
      // A grid finer than the frame gives zero-size cells and an empty pixel box.
      apply_setting(3, 2, 5, 2, 1, 32'd50);
      run_random(140);
      // Zone count of zero selects flag mode.
      apply_setting(5, 3, 0, 1000, 700, 32'd3000);
      run_random(140);
      // Column count of zero selects flag mode.
      apply_setting(0, 4, 8, 640, 480, 32'd100);
      run_random(140);
      // Single row with zero-width cells.
      apply_setting(16, 1, 16, 1, 4096, 32'd200);
      run_random(140);
      apply_setting(7, 3, 12, 4095, 2047, 32'd2000000);
      run_random(140);
      apply_setting($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                    $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 5000));
      run_random(140);

      settle();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ motion_zone_bbox_hold_unit.f @@
+incdir+rtl
rtl/mzbh_pkg.sv
rtl/mzbh_div.sv
rtl/motion_zone_bbox_hold_unit.sv
tb/mzbh_frame_checker.sv
tb/tb_motion_zone_bbox_hold_unit.sv
